// ===== hdl/xor_frame_receiver_resync_defines.svh =====
// Assertion macros shared by the frame receiver checkers.
`ifndef XOR_FRAME_RECEIVER_RESYNC_DEFINES_SVH
`define XOR_FRAME_RECEIVER_RESYNC_DEFINES_SVH

// Clocked check that is switched off while reset is held.
`define XFRR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also covers reset cycles.
`define XFRR_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/xfrr_pkg.sv =====
// Types and constants of the XOR frame receiver.
`default_nettype none
package xfrr_pkg;

  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned HELD_BYTES = 7;
  localparam int unsigned FILL_W     = 3;

  localparam logic [7:0]        DEV_ADDR_RESET = 8'd1;
  localparam logic [FILL_W-1:0] FILL_FULL      = FILL_W'(HELD_BYTES);

  // Register index codes (index is paddr above the byte offset).
  localparam logic REG_DEVICE_ADDRESS = 1'b0;

  typedef struct packed {
    logic [7:0]  command_id;
    logic [31:0] payload;
  } xfrr_result_t;

  typedef struct packed {
    logic         valid;
    xfrr_result_t res;
  } xfrr_push_t;

endpackage
`default_nettype wire

// ===== hdl/xor_frame_receiver_resync.sv =====
// Top level of the fixed-length frame receiver with XOR checksum and resync.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   in_rx_byte[7:0]
//  out      source     out_valid / out_stall out_command_id[7:0], out_payload[31:0]
//  cfg      APB slave  psel/penable/pready   paddr[2:0], pwdata/prdata[31:0]
//
// One byte request is taken per cycle while in_stall is low; the frame check
// is a single XOR and compare on the seven held bytes plus the incoming byte,
// and a passing frame is registered in the result register or skid entry.
// The result register plus one skid entry set in_stall: it rises only once a
// second result is parked behind a stalled one.
// Reset (rst_n low, synchronous) empties the window and both result entries
// and loads device_address with 1; window bytes themselves are not cleared.
`default_nettype none
module xor_frame_receiver_resync (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [7:0]                  out_command_id,
  output logic      [31:0]                 out_payload,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [xfrr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  logic                   accept;
  logic                   buf_full;
  logic [7:0]             device_address;
  xfrr_pkg::xfrr_push_t   push;
  xfrr_pkg::xfrr_result_t res;

  // hold off new bytes only while the skid entry is occupied
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  xfrr_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .device_address (device_address)
  );

  xfrr_window u_win (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .rx_byte        (in_rx_byte),
    .device_address (device_address),
    .push           (push)
  );

  xfrr_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res),
    .full      (buf_full)
  );

  assign out_command_id = res.command_id;
  assign out_payload    = res.payload;

endmodule
`default_nettype wire

// ===== hdl/xfrr_cfg_regs.sv =====
// Configuration register bank with an APB-style access port.
`default_nettype none
module xfrr_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [xfrr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output logic      [7:0]                 device_address
);

  logic [7:0] dev_addr_r;
  logic [7:0] dev_addr_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready &&
                  (paddr[2] == xfrr_pkg::REG_DEVICE_ADDRESS);

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    if (wr_en) begin
      dev_addr_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= xfrr_pkg::DEV_ADDR_RESET;
    end else begin
      dev_addr_r <= dev_addr_nxt;
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == xfrr_pkg::REG_DEVICE_ADDRESS) begin
      prdata = {24'd0, dev_addr_r};
    end
  end

  assign device_address = dev_addr_r;

endmodule
`default_nettype wire

// ===== hdl/xfrr_window.sv =====
// Sliding byte window with address and XOR checksum check.
`default_nettype none
module xfrr_window (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          device_address,
  output xfrr_pkg::xfrr_push_t     push
);

  logic [7:0] win_r [xfrr_pkg::HELD_BYTES];
  logic [xfrr_pkg::FILL_W-1:0] fill_r;
  logic [xfrr_pkg::FILL_W-1:0] fill_nxt;
  logic [15:0] sum;
  logic        frame_ok;

  // Newest byte always enters at the top; the oldest falls off the bottom.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < int'(xfrr_pkg::HELD_BYTES) - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[xfrr_pkg::HELD_BYTES-1] <= rx_byte;
    end
  end

  assign sum = {win_r[0], win_r[1]} ^ {win_r[2], win_r[3]} ^ {win_r[4], win_r[5]};
  assign frame_ok = (fill_r == xfrr_pkg::FILL_FULL) &&
                    (win_r[0] == device_address) &&
                    (sum == {win_r[6], rx_byte});

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (frame_ok) begin
        fill_nxt = '0;
      end else if (fill_r != xfrr_pkg::FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign push.valid          = accept && frame_ok;
  assign push.res.command_id = win_r[1];
  assign push.res.payload    = {win_r[2], win_r[3], win_r[4], win_r[5]};

endmodule
`default_nettype wire

// ===== hdl/xfrr_out_buf.sv =====
// Result register with one skid entry.
`default_nettype none
module xfrr_out_buf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire xfrr_pkg::xfrr_push_t push,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output xfrr_pkg::xfrr_result_t    out_res,
  output logic                      full
);

  logic                   main_v_r, main_v_nxt;
  logic                   skid_v_r, skid_v_nxt;
  xfrr_pkg::xfrr_result_t main_r, main_nxt;
  xfrr_pkg::xfrr_result_t skid_r, skid_nxt;
  logic                   free;

  assign free = !main_v_r || !out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (free) begin
      if (skid_v_r) begin
        // advance the skid entry; no push can arrive while it is held
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = push.res;
        main_v_nxt = push.valid;
      end
    end else if (push.valid) begin
      skid_nxt   = push.res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_res   = main_r;
  assign full      = skid_v_r;

endmodule
`default_nettype wire

// ===== hdl/xfrr_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none
`include "xor_frame_receiver_resync_defines.svh"
module xfrr_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [7:0]                  in_rx_byte,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [7:0]                  out_command_id,
  input wire logic [31:0]                 out_payload,
  input wire logic                        psel,
  input wire logic                        penable,
  input wire logic                        pwrite,
  input wire logic [xfrr_pkg::ADDR_W-1:0] paddr,
  input wire logic [31:0]                 pwdata,
  input wire logic [31:0]                 prdata,
  input wire logic                        pready
);

  `XFRR_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_command_id) && $stable(out_payload), "stalled result changed")
  `XFRR_ASSERT(a_in_hold, clk, rst_n, in_valid && in_stall |=> in_valid && $stable(in_rx_byte), "stalled request changed")
  `XFRR_ASSERT(a_stall_pending, clk, rst_n, in_stall |-> out_valid, "input stalled with no result pending")
  `XFRR_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall, "result pending after reset")
  `XFRR_ASSERT(a_cfg_readback, clk, rst_n, (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !paddr[2]) |-> prdata[7:0] == $past(pwdata[7:0]), "device address readback mismatch")

endmodule

bind xor_frame_receiver_resync xfrr_checker u_chk (.*);
`default_nettype wire
